[rtl/percentile_rank_tracker_assert.svh]
// Assertion macros for the percentile rank tracker.
// Used by percentile_rank_tracker.sv; no other dependencies.
`ifndef PERCENTILE_RANK_TRACKER_ASSERT_SVH
`define PERCENTILE_RANK_TRACKER_ASSERT_SVH

// same-cycle implication
`define PRT_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PRT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/prt_pkg.sv]
// Shared widths, request codes, divider status type and a saturating helper
// for the percentile rank tracker. No dependencies.
package prt_pkg;

	localparam int UID_W     = 16;
	localparam int PROG_W    = 10;
	localparam int CNT_W     = 17;
	localparam int OUT_W     = 16;
	localparam int RATIO_W   = 17;
	localparam int DIV_STEPS = 17;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	localparam logic [RATIO_W-1:0] ONE_Q16 = 17'h10000;
	localparam logic [OUT_W-1:0]   CNT_SAT = 16'hFFFF;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [OUT_W-1:0] sat16(input logic [CNT_W-1:0] v);
		sat16 = (v > CNT_W'(CNT_SAT)) ? CNT_SAT : v[OUT_W-1:0];
	endfunction

endpackage

[rtl/prt_div.sv]
// Restoring divider: quotient = (dividend << 16) / divisor, dividend <= divisor.
// One quotient bit per cycle. Depends on prt_pkg.
module prt_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [prt_pkg::CNT_W-1:0]     dividend,
	input  logic [prt_pkg::CNT_W-1:0]     divisor,
	output prt_pkg::div_stat_t            stat,
	output logic [prt_pkg::RATIO_W-1:0]   quotient
);

	logic [prt_pkg::CNT_W:0]           rem_q;
	logic [prt_pkg::CNT_W-1:0]         dvs_q;
	logic [prt_pkg::RATIO_W-1:0]       quo_q;
	logic [prt_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic                              busy_q;
	logic                              done_q;
	logic                              ge;
	logic [prt_pkg::CNT_W:0]           rem_sub;

	assign ge      = rem_q >= {1'b0, dvs_q};
	assign rem_sub = ge ? (rem_q - {1'b0, dvs_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == prt_pkg::DIV_CNT_W'(prt_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			// remainder after subtract is below divisor, so the shift fits
			rem_q <= {rem_sub[prt_pkg::CNT_W-1:0], 1'b0};
			quo_q <= {quo_q[prt_pkg::RATIO_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

[rtl/percentile_rank_tracker.sv]
// Percentile rank tracker: per-user progress table plus progress histogram.
// Record transfer: busy through lookup and table update (never when ignored), no result. Query
// transfer: result from the lookup for an inactive or sole user, else after the sweep and divide.
// Throughput: one transfer at a time; the histogram sweep (one read per bin) sets it.
// Reset: async, active low; then a clearing pass over max(MAX_USERS, MAX_PROGRESS)
// entries with busy high. The receiver cannot stall; results are strobed once.
module percentile_rank_tracker #(
	parameter int MAX_USERS    = 65536,
	parameter int MAX_PROGRESS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [prt_pkg::UID_W-1:0]     user_id,
	input  logic [prt_pkg::PROG_W-1:0]    progress,
	output logic                          result_valid,
	output logic [prt_pkg::RATIO_W-1:0]   ratio_q16,
	output logic [prt_pkg::OUT_W-1:0]     below_count,
	output logic [prt_pkg::OUT_W-1:0]     others_count
);

	localparam int UA_W      = $clog2(MAX_USERS);
	localparam int PA_W      = $clog2(MAX_PROGRESS);
	localparam int CLR_DEPTH = (MAX_USERS > MAX_PROGRESS) ? MAX_USERS : MAX_PROGRESS;
	localparam int CLR_W     = $clog2(CLR_DEPTH);
	// bin sum can exceed the active count only through stale wrap; keep full width
	localparam int ACC_W     = prt_pkg::CNT_W + PA_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_DEC,
		S_INC,
		S_SUM,
		S_DIV,
		S_WAIT
	} state_t;

	// ---------------------------------------------------------------
	// Storage: user table (progress per user, 0 = inactive) and histogram
	// ---------------------------------------------------------------
	logic [prt_pkg::PROG_W-1:0] umem [MAX_USERS];
	logic [prt_pkg::CNT_W-1:0]  hmem [MAX_PROGRESS];

	logic [prt_pkg::PROG_W-1:0] u_rd_q;
	logic [prt_pkg::CNT_W-1:0]  h_rd_q;

	logic                       u_we;
	logic [UA_W-1:0]            u_wa;
	logic [prt_pkg::PROG_W-1:0] u_wd;
	logic [UA_W-1:0]            u_ra;
	logic                       h_we;
	logic [PA_W-1:0]            h_wa;
	logic [prt_pkg::CNT_W-1:0]  h_wd;
	logic [PA_W-1:0]            h_ra;

	// ---------------------------------------------------------------
	// Control state
	// ---------------------------------------------------------------
	state_t                     state_q;
	logic [CLR_W-1:0]           clr_q;
	logic [UA_W-1:0]            uid_q;
	logic [prt_pkg::PROG_W-1:0] prog_q;
	logic                       req_q;
	logic                       uid_ok_q;
	logic [prt_pkg::PROG_W-1:0] old_q;
	logic [PA_W-1:0]            val_q;
	logic [PA_W-1:0]            idx_q;
	logic [ACC_W-1:0]           acc_q;
	logic [prt_pkg::CNT_W-1:0]  active_q;

	logic                        result_valid_q;
	logic [prt_pkg::RATIO_W-1:0] ratio_q;
	logic [prt_pkg::OUT_W-1:0]   below_q;
	logic [prt_pkg::OUT_W-1:0]   others_q;

	// ---------------------------------------------------------------
	// Derived values
	// ---------------------------------------------------------------
	logic                        accept;
	logic                        uid_ok;
	logic                        rec_ok;
	logic [prt_pkg::PROG_W-1:0]  old_w;
	logic [prt_pkg::PROG_W-1:0]  qval_w;
	logic [prt_pkg::CNT_W-1:0]   others_w;
	logic [prt_pkg::CNT_W-1:0]   below_w;
	logic                        clr_last;

	logic                        div_start;
	prt_pkg::div_stat_t          div_stat;
	logic [prt_pkg::RATIO_W-1:0] div_quo;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign uid_ok   = 32'(user_id) < MAX_USERS;
	// progress 0 and values past the histogram are ignored on record
	assign rec_ok   = uid_ok && (progress != '0) && (32'(progress) < MAX_PROGRESS);
	assign old_w    = u_rd_q;
	// out-of-range user reads as inactive
	assign qval_w   = uid_ok_q ? u_rd_q : '0;
	assign others_w = (active_q == '0) ? '0 : (active_q - 1'b1);
	// clamp bin sum to others count
	assign below_w  = (acc_q > ACC_W'(others_w)) ? others_w : acc_q[prt_pkg::CNT_W-1:0];
	assign clr_last = (clr_q == CLR_W'(CLR_DEPTH - 1));

	// ---------------------------------------------------------------
	// Memory port steering
	// ---------------------------------------------------------------
	always_comb begin
		u_we      = 1'b0;
		u_wa      = uid_q;
		u_wd      = prog_q;
		u_ra      = UA_W'(user_id);
		h_we      = 1'b0;
		h_wa      = PA_W'(prog_q);
		h_wd      = h_rd_q + 1'b1;
		h_ra      = PA_W'(prog_q);
		div_start = 1'b0;
		case (state_q)
			S_CLEAR: begin
				u_we = 32'(clr_q) < MAX_USERS;
				u_wa = UA_W'(clr_q);
				u_wd = '0;
				h_we = 32'(clr_q) < MAX_PROGRESS;
				h_wa = PA_W'(clr_q);
				h_wd = '0;
			end
			S_LOOKUP: begin
				if (req_q == prt_pkg::REQ_RECORD) begin
					u_we = 1'b1;
					// old value 0: new user, go straight to increment
					h_ra = (old_w == '0) ? PA_W'(prog_q) : PA_W'(old_w);
				end else begin
					h_ra = '0;
				end
			end
			S_DEC: begin
				// old and new bins differ here, so read and write never collide
				h_we = 1'b1;
				h_wa = PA_W'(old_q);
				h_wd = h_rd_q - 1'b1;
				h_ra = PA_W'(prog_q);
			end
			S_INC: begin
				h_we = 1'b1;
			end
			S_SUM: begin
				h_ra = idx_q;
			end
			S_DIV: begin
				div_start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (u_we) begin
			umem[u_wa] <= u_wd;
		end
		u_rd_q <= umem[u_ra];
	end

	always_ff @(posedge clk) begin
		if (h_we) begin
			hmem[h_wa] <= h_wd;
		end
		h_rd_q <= hmem[h_ra];
	end

	// ---------------------------------------------------------------
	// Sequencer: state and registered result
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			active_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					uid_q    <= UA_W'(user_id);
					prog_q   <= progress;
					req_q    <= req_type;
					uid_ok_q <= uid_ok;
					// ignored records leave the block idle
					if (accept && (req_type == prt_pkg::REQ_QUERY || rec_ok)) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					if (req_q == prt_pkg::REQ_RECORD) begin
						old_q <= old_w;
						if (old_w == prog_q) begin
							state_q <= S_IDLE;
						end else if (old_w == '0) begin
							active_q <= active_q + 1'b1;
							state_q  <= S_INC;
						end else begin
							state_q <= S_DEC;
						end
					end else if (qval_w == '0) begin
						ratio_q        <= '0;
						below_q        <= '0;
						others_q       <= prt_pkg::sat16(others_w);
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end else if (others_w == '0) begin
						ratio_q        <= prt_pkg::ONE_Q16;
						below_q        <= '0;
						others_q       <= '0;
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end else begin
						// bin 0 read already issued
						val_q   <= PA_W'(qval_w);
						idx_q   <= PA_W'(1);
						acc_q   <= '0;
						state_q <= S_SUM;
					end
				end
				S_DEC: begin
					state_q <= S_INC;
				end
				S_INC: begin
					state_q <= S_IDLE;
				end
				S_SUM: begin
					acc_q <= acc_q + ACC_W'(h_rd_q);
					if (idx_q == val_q) begin
						state_q <= S_DIV;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DIV: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_stat.done) begin
						ratio_q        <= div_quo;
						below_q        <= prt_pkg::sat16(below_w);
						others_q       <= prt_pkg::sat16(others_w);
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	prt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (below_w),
		.divisor  (others_w),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign result_valid = result_valid_q;
	assign ratio_q16    = ratio_q;
	assign below_count  = below_q;
	assign others_count = others_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
`include "percentile_rank_tracker_assert.svh"

	`PRT_ASSERT_NOW(a_res_idle, clk, arst_n, result_valid, !busy, "result while busy")
	`PRT_ASSERT_NEXT(a_query_busy, clk, arst_n, accept && req_type == prt_pkg::REQ_QUERY, busy, "query lost")
	`PRT_ASSERT_NOW(a_below_le, clk, arst_n, result_valid, below_count <= others_count, "below > others")
	`PRT_ASSERT_NEXT(a_res_once, clk, arst_n, result_valid, !result_valid, "result strobe repeated")
	`PRT_ASSERT_NOW(a_div_idle, clk, arst_n, !busy, !div_stat.busy, "divider active while idle")

endmodule
